// ----- rtl/ifbs_pkg.sv -----
// Shared constants and types of the information frame byte stuffer.
package ifbs_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
   localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7D;
   localparam logic [BYTE_W-1:0] STUFF_MASK = 8'h20;
   localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h03;
   localparam logic [BYTE_W-1:0] CONTROL_RESET = 8'h00;

   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL = 1'd1;

   typedef struct packed {
      logic              header;
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] control;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [BYTE_W-1:0] check;
   } ifbs_job_type;

   localparam int JOB_W = $bits(ifbs_job_type);

   function automatic logic needs_escape(input logic [BYTE_W-1:0] value);
      return (value == FLAG_BYTE) || (value == ESC_BYTE);
   endfunction

endpackage

// ----- rtl/ifbs_if.sv -----
// Valid/ready channel interfaces for payload beats and framed byte beats.
interface ifbs_req_if
   import ifbs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ifbs_rsp_if
   import ifbs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              run_end;
   logic              frame_end;

   modport source (output valid, output out_byte, output run_end, output frame_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_end, input frame_end,
                 output ready);
endinterface

// ----- rtl/ifbs_queue.sv -----
// Small register queue of frame jobs between the front and back ends.
module ifbs_queue
   import ifbs_pkg::*;
#(
   parameter int Width = JOB_W,
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [Width-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [Width-1:0] pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   logic [Width-1:0] entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/ifbs_front.sv -----
// Front end: header registers, frame tracking and payload check per accepted beat.
module ifbs_front
   import ifbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   ifbs_req_if.sink               req_chan,
   output logic                   job_valid,
   input  logic                   job_ready,
   output ifbs_job_type           job
);

   logic [BYTE_W-1:0] address_ff;
   logic [BYTE_W-1:0] control_ff;
   logic [BYTE_W-1:0] check_ff, check_in;
   logic              inside_ff, inside_in;
   logic              accept;
   logic [BYTE_W-1:0] check_new;

   assign req_chan.ready = job_ready;
   assign job_valid      = req_chan.valid;
   assign accept         = req_chan.valid && job_ready;

   always_comb begin
      check_new   = (inside_ff ? check_ff : '0) ^ req_chan.data_byte;
      job.header  = !inside_ff;
      job.address = address_ff;
      job.control = control_ff;
      job.data    = req_chan.data_byte;
      job.last    = req_chan.last_byte;
      job.check   = check_new;
      inside_in   = inside_ff;
      check_in    = check_ff;
      if (accept) begin
         inside_in = !req_chan.last_byte;
         check_in  = req_chan.last_byte ? '0 : check_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= ADDRESS_RESET;
         control_ff <= CONTROL_RESET;
         check_ff   <= '0;
         inside_ff  <= 1'b0;
      end else begin
         check_ff  <= check_in;
         inside_ff <= inside_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ADDRESS: address_ff <= csr_wdata[BYTE_W-1:0];
               CSR_CONTROL: control_ff <= csr_wdata[BYTE_W-1:0];
            endcase
         end
      end
   end

endmodule

// ----- rtl/ifbs_back.sv -----
// Back end: byte sequencer that emits header, stuffed payload, check and closing flag.
module ifbs_back
   import ifbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   output logic         job_ready,
   input  ifbs_job_type job,
   ifbs_rsp_if.source   rsp_chan
);

   typedef enum logic [3:0] {
      STEP_FLAG,
      STEP_ADDR,
      STEP_CTRL,
      STEP_HCHK,
      STEP_DATA,
      STEP_DATA2,
      STEP_CHK,
      STEP_CHK2,
      STEP_CLOSE
   } step_type;

   step_type          step_ff, step_in, step_next;
   ifbs_job_type      cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              run_end_ff;
   logic              frame_end_ff;

   logic              take, emit, step_done, load;
   logic [BYTE_W-1:0] byte_now;
   logic              run_end_now, frame_end_now;
   logic              data_esc, chk_esc;

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_byte  = byte_ff;
   assign rsp_chan.run_end   = run_end_ff;
   assign rsp_chan.frame_end = frame_end_ff;

   always_comb begin
      data_esc      = needs_escape(cur_ff.data);
      chk_esc       = needs_escape(cur_ff.check);
      byte_now      = FLAG_BYTE;
      run_end_now   = 1'b0;
      frame_end_now = 1'b0;
      step_done     = 1'b0;
      step_next     = step_ff;
      unique case (step_ff)
         STEP_FLAG: begin
            byte_now  = FLAG_BYTE;
            step_next = STEP_ADDR;
         end
         STEP_ADDR: begin
            byte_now  = cur_ff.address;
            step_next = STEP_CTRL;
         end
         STEP_CTRL: begin
            byte_now  = cur_ff.control;
            step_next = STEP_HCHK;
         end
         STEP_HCHK: begin
            byte_now  = cur_ff.address ^ cur_ff.control;
            step_next = STEP_DATA;
         end
         STEP_DATA: begin
            byte_now = data_esc ? ESC_BYTE : cur_ff.data;
            if (data_esc) begin
               step_next = STEP_DATA2;
            end else if (cur_ff.last) begin
               step_next = STEP_CHK;
            end else begin
               step_done   = 1'b1;
               run_end_now = 1'b1;
            end
         end
         STEP_DATA2: begin
            byte_now = cur_ff.data ^ STUFF_MASK;
            if (cur_ff.last) begin
               step_next = STEP_CHK;
            end else begin
               step_done   = 1'b1;
               run_end_now = 1'b1;
            end
         end
         STEP_CHK: begin
            byte_now  = chk_esc ? ESC_BYTE : cur_ff.check;
            step_next = chk_esc ? STEP_CHK2 : STEP_CLOSE;
         end
         STEP_CHK2: begin
            byte_now  = cur_ff.check ^ STUFF_MASK;
            step_next = STEP_CLOSE;
         end
         STEP_CLOSE: begin
            byte_now      = FLAG_BYTE;
            run_end_now   = 1'b1;
            frame_end_now = 1'b1;
            step_done     = 1'b1;
         end
         default: begin
            byte_now  = FLAG_BYTE;
            step_next = STEP_FLAG;
         end
      endcase

      take      = !valid_ff || rsp_chan.ready;
      emit      = busy_ff && take;
      load      = job_valid && (!busy_ff || (emit && step_done));
      job_ready = !busy_ff || (emit && step_done);

      busy_in = busy_ff;
      step_in = step_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = 1'b1;
         cur_in  = job;
         step_in = job.header ? STEP_FLAG : STEP_DATA;
      end else if (emit) begin
         busy_in = !step_done;
         step_in = step_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         step_ff  <= STEP_FLAG;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         if (take) begin
            valid_ff <= busy_ff;
         end
      end
      cur_ff <= cur_in;
      if (emit) begin
         byte_ff      <= byte_now;
         run_end_ff   <= run_end_now;
         frame_end_ff <= frame_end_now;
      end
   end

endmodule

// ----- rtl/info_frame_byte_stuffer_top.sv -----
// Information frame byte stuffer: payload beats in, framed and stuffed byte beats out.
//
// req_chan carries one payload byte per beat with last_byte marking the end of a
// frame. rsp_chan carries one line byte per beat: run_end marks the final byte
// caused by one payload beat, frame_end marks the closing flag. The first payload
// beat of a frame is preceded by flag, address, control and header check; the
// closing flag follows the stuffed check after a last beat.
// csr_wr_en writes address (index 0) or control (index 1); the values are taken
// when the next frame header is built.
// A beat passes the queue, the back end job register and the output register on its
// way to rsp_chan. The back end emits one byte per cycle while it is busy and the
// receiver takes bytes, so a payload beat yields one or two line bytes, plus four
// for a header and two or three for a frame close. A queue of QueueDepth jobs lets
// the front accept beats while the back end is still busy.
// Reset clears frame state, empties the queue and loads address 0x03, control 0x00.
// When the receiver holds rsp_chan.ready low, the output byte holds, the queue
// fills and req_chan.ready drops.
module info_frame_byte_stuffer_top
   import ifbs_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   ifbs_req_if.sink               req_chan,
   ifbs_rsp_if.source             rsp_chan
);

   ifbs_job_type front_job;
   ifbs_job_type back_job;
   logic         front_valid, front_ready;
   logic         back_valid, back_ready;

   ifbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job       (front_job)
   );

   ifbs_queue #(
      .Width (JOB_W),
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   ifbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job       (back_job),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- tb/info_frame_byte_stuffer_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the information frame byte stuffer: directed and random payload beats against a predictor.
module info_frame_byte_stuffer_top_tb;
   import ifbs_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BEATS = 400;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_end;
      logic              frame_end;
   } line_beat_type;

   class frame_scoreboard;
      logic [BYTE_W-1:0] address_reg;
      logic [BYTE_W-1:0] control_reg;
      logic [BYTE_W-1:0] running_check;
      bit                frame_open;
      line_beat_type     pending_beats[$];
      int                mismatches;

      function new();
         address_reg = ADDRESS_RESET;
         control_reg = CONTROL_RESET;
         running_check = '0;
         frame_open = 1'b0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_ADDRESS) begin
            address_reg = value;
         end else if (index == CSR_CONTROL) begin
            control_reg = value;
         end
      endfunction

      function void push_plain(logic [BYTE_W-1:0] value);
         line_beat_type beat;
         beat.out_byte = value;
         beat.run_end = 1'b0;
         beat.frame_end = 1'b0;
         pending_beats.push_back(beat);
      endfunction

      function void push_stuffed(logic [BYTE_W-1:0] value);
         if (value == FLAG_BYTE || value == ESC_BYTE) begin
            push_plain(ESC_BYTE);
            push_plain(value ^ STUFF_MASK);
         end else begin
            push_plain(value);
         end
      endfunction

      function void note_payload(logic [BYTE_W-1:0] data, logic last);
         if (!frame_open) begin
            push_plain(FLAG_BYTE);
            push_plain(address_reg);
            push_plain(control_reg);
            push_plain(address_reg ^ control_reg);
            running_check = '0;
            frame_open = 1'b1;
         end
         push_stuffed(data);
         running_check = running_check ^ data;
         if (last) begin
            push_stuffed(running_check);
            push_plain(FLAG_BYTE);
            pending_beats[pending_beats.size()-1].frame_end = 1'b1;
            running_check = '0;
            frame_open = 1'b0;
         end
         pending_beats[pending_beats.size()-1].run_end = 1'b1;
      endfunction

      function void check_line_byte(logic [BYTE_W-1:0] out_byte, logic run_end, logic frame_end);
         line_beat_type want;
         line_beat_type got;
         got.out_byte = out_byte;
         got.run_end = run_end;
         got.frame_end = frame_end;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected line byte %h run_end %b frame_end %b",
                        $realtime, out_byte, run_end, frame_end);
            end
         end else begin
            want = pending_beats.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: line byte mismatch: expected %h/%b/%b, got %h/%b/%b",
                           $realtime, want.out_byte, want.run_end, want.frame_end,
                           out_byte, run_end, frame_end);
               end
            end
         end
      endfunction

      function int outstanding();
         return pending_beats.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ifbs_req_if req_bus ();
   ifbs_rsp_if rsp_bus ();

   info_frame_byte_stuffer_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   frame_scoreboard sb = new();

   int beats_sent;
   bit no_idle;
   bit hold_request;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic send_payload(input logic [BYTE_W-1:0] data, input logic last);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.last_byte <= last;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sb.note_payload(data, last);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.outstanding() > 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(index, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_random_register();
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      int                     pick;
      index = $urandom_range(1) ? CSR_CONTROL : CSR_ADDRESS;
      pick = $urandom_range(99);
      if (pick < 15) begin
         value = '0;
      end else if (pick < 30) begin
         value = '1;
      end else if (pick < 40) begin
         value = FLAG_BYTE;
      end else if (pick < 50) begin
         value = ESC_BYTE;
      end else begin
         value = CSR_DATA_W'($urandom_range(255));
      end
      write_register(index, value);
   endtask

   function automatic logic [BYTE_W-1:0] random_payload_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         return FLAG_BYTE;
      end else if (pick < 30) begin
         return ESC_BYTE;
      end else if (pick < 35) begin
         return $urandom_range(1) ? 8'hFF : 8'h00;
      end
      return BYTE_W'($urandom_range(255));
   endfunction

   task automatic send_random_frame(input int len, input bit split);
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] xor_acc;
      int                i;
      xor_acc = '0;
      for (i = 0; i < len; i++) begin
         data = random_payload_byte();
         // steer the check byte onto a flag or escape value
         if (i == len - 1 && $urandom_range(9) < 2) begin
            data = xor_acc ^ ($urandom_range(1) ? FLAG_BYTE : ESC_BYTE);
         end
         if (split && i > 0 && i == len / 2) begin
            wait_idle();
            write_random_register();
         end
         send_payload(data, i == len - 1);
         xor_acc = xor_acc ^ data;
      end
   endtask

   // receiver: random back-pressure plus one long hold-off
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= 29);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_line_byte(rsp_bus.out_byte, rsp_bus.run_end, rsp_bus.frame_end);
      end
   end

   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || csr_wr_en) begin
            stall = 0;
         end else begin
            stall++;
         end
      end
      $display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int  len;
      int  random_goal;
      bit  hold_issued;
      int  failures;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_ADDRESS;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      beats_sent = 0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      hold_issued = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-beat frames, then one multi-beat frame, at reset header values
      send_payload(8'h00, 1'b1);
      send_payload(8'hFF, 1'b1);
      send_payload(FLAG_BYTE, 1'b1);
      send_payload(ESC_BYTE, 1'b1);
      send_payload(FLAG_BYTE, 1'b0);
      send_payload(ESC_BYTE, 1'b0);
      send_payload(8'h5E, 1'b0);
      send_payload(8'h5D, 1'b0);
      send_payload(STUFF_MASK, 1'b0);
      send_payload(8'h7C, 1'b0);
      send_payload(8'hFF, 1'b1);
      // check byte lands on flag, then on escape
      send_payload(8'h12, 1'b0);
      send_payload(8'h6C, 1'b1);
      send_payload(8'h70, 1'b0);
      send_payload(8'h0D, 1'b1);
      // header fields equal to flag and escape go out unstuffed
      wait_idle();
      write_register(CSR_ADDRESS, FLAG_BYTE);
      write_register(CSR_CONTROL, ESC_BYTE);
      send_payload(8'h41, 1'b1);
      // registers rewritten inside a frame apply at the next header
      wait_idle();
      write_register(CSR_ADDRESS, 8'hFF);
      write_register(CSR_CONTROL, 8'hFF);
      send_payload(8'hA5, 1'b0);
      wait_idle();
      write_register(CSR_ADDRESS, 8'h00);
      write_register(CSR_CONTROL, 8'h00);
      send_payload(8'h5A, 1'b1);
      send_payload(8'h01, 1'b1);

      random_goal = beats_sent + RANDOM_BEATS;
      while (beats_sent < random_goal) begin
         no_idle = (beats_sent >= random_goal - 180) && (beats_sent < random_goal - 100);
         if (!hold_issued && beats_sent >= random_goal - 300) begin
            hold_request = 1'b1;
            hold_issued = 1'b1;
         end
         if ($urandom_range(99) < 12) begin
            wait_idle();
            write_random_register();
            write_random_register();
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
         send_random_frame(len, $urandom_range(9) == 0);
      end
      no_idle = 1'b0;

      wait_idle();
      repeat (8) @(posedge clock);
      failures = sb.mismatches + sb.outstanding();
      if (sb.outstanding() > 0) begin
         $display("%0d expected line bytes never arrived", sb.outstanding());
      end
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
